/* design/staged_fan_hysteresis_control_defines.svh */
// Assertion macros used by the port checker of the fan stage controller.
// Depends on nothing; each macro expects a clock and an active-high reset name.
`ifndef STAGED_FAN_HYSTERESIS_CONTROL_DEFINES_SVH
`define STAGED_FAN_HYSTERESIS_CONTROL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFHC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in fan stage controller");

// The consequent must hold in the cycle after the antecedent.
`define SFHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in fan stage controller");

`endif

/* design/sfhc_pkg.sv */
// Types and constants of the staged fan hysteresis controller.
// Used by the top level and by its port checker; depends on nothing.
package sfhc_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int SECONDS_W   = 6;
  localparam int MAP_W       = 8;
  localparam int CURRENT_W   = 9;
  localparam int TEMP_W      = 20;
  localparam int MEAS_W      = 13;
  localparam int STAGE_W     = 4;
  localparam int RELAY_SEL_W = 2;
  localparam int LEVEL_W     = 8;
  localparam int TEST_TEMP_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 40;

  // Number of stages in use; stages above it are never demanded.
  localparam int STAGE_COUNT = 4;

  localparam int SAMPLE_MAX   = 4095;
  localparam int CURRENT_NUM  = 55;
  localparam int CURRENT_DEN  = 819;
  localparam int CURRENT_MAX  = 275;
  localparam int CURRENT_ZERO = 40;
  localparam int TEMP_SLOPE   = 15;

  localparam logic [SECONDS_W-1:0] HOLD_SEC_LATE  = 6'd59;
  localparam logic [SECONDS_W-1:0] HOLD_SEC_ZERO  = 6'd0;
  localparam logic [SECONDS_W-1:0] HOLD_SEC_EARLY = 6'd1;

  localparam logic [CFG_INDEX_W-1:0] REG_START_ONE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_TWO        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_THREE      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_FOUR       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TEST_MODE        = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TEST_TEMPERATURE = 3'd6;

  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [CURRENT_W-1:0] current_t;
  typedef logic [TEMP_W-1:0]    temperature_t;
  typedef logic [STAGE_W-1:0]   stage_bits_t;

  localparam level_t RESET_START_ONE   = 8'd55;
  localparam level_t RESET_START_TWO   = 8'd65;
  localparam level_t RESET_START_THREE = 8'd75;
  localparam level_t RESET_START_FOUR  = 8'd85;
  localparam level_t RESET_HYSTERESIS  = 8'd5;

endpackage

/* design/staged_fan_hysteresis_control.sv */
// Staged fan controller: averages loop current samples, derives oil temperature
// and switches four fan stages with hysteresis onto rotated relays.
// Depends on sfhc_pkg.
//
//   Channel  Signals                         Transfer carries
//   input    s_tvalid s_tready s_tdata       adc_sample, seconds, order_map
//   output   m_tvalid m_tready m_tdata/tuser one reading per completed average
//   config   cfg_write cfg_index cfg_data    one register write per cycle
//
// One sample is taken every cycle. A reading leaves three register stages
// after its last sample: sum latch, constant-reciprocal multiply, then the
// temperature, stage and relay decision that also updates the stage state.
// Reset is synchronous and clears counters, stage flags, relays and valid flags.
// While the output is stalled, samples that do not complete a reading are
// still taken; the last sample of a reading waits until the pipeline has room.
module staged_fan_hysteresis_control #(
  parameter int SAMPLES_PER_READING = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // adc_sample[11:0], seconds[17:12], order_map[25:18], zero fill above
  input  logic [sfhc_pkg::IN_DATA_W-1:0]         s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // loop_current[8:0], temperature[28:9], stage_demand[32:29],
  // relay_drive[36:33], zero fill above
  output logic [sfhc_pkg::OUT_DATA_W-1:0]        m_tdata,
  // relays_updated[0]
  output logic                                   m_tuser,
  input  logic                                   cfg_write,
  input  logic [sfhc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [sfhc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
  localparam int SUM_W = $clog2(SAMPLES_PER_READING * sfhc_pkg::SAMPLE_MAX + 1);
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_READING - 1);

  // The average current is sum * 55 / (N * 819); the shift is chosen so that
  // the rounded-up reciprocal gives the exact floor for every reachable sum.
  localparam logic [63:0] Divisor = 64'(SAMPLES_PER_READING) * 64'(sfhc_pkg::CURRENT_DEN);
  localparam logic [63:0] SumMax = 64'(SAMPLES_PER_READING) * 64'(sfhc_pkg::SAMPLE_MAX);
  localparam int RECIP_SHIFT = $clog2(SumMax * Divisor + 64'd1);
  localparam logic [63:0] RECIP =
    ((64'(sfhc_pkg::CURRENT_NUM) << RECIP_SHIFT) + Divisor - 64'd1) / Divisor;
  localparam int RECIP_W = $clog2(RECIP + 64'd1);
  localparam int PROD_W = SUM_W + RECIP_W;

  sfhc_pkg::level_t start_level [sfhc_pkg::STAGE_W];
  sfhc_pkg::level_t hysteresis_width;
  logic test_mode;
  logic [sfhc_pkg::TEST_TEMP_W-1:0] test_temperature;

  logic [SUM_W-1:0] sample_sum;
  logic [CNT_W-1:0] sample_count;
  sfhc_pkg::stage_bits_t stage_flags;
  sfhc_pkg::stage_bits_t relay_outputs;

  logic reading_valid;
  logic [SUM_W-1:0] reading_sum;
  logic [sfhc_pkg::SECONDS_W-1:0] reading_seconds;
  logic [sfhc_pkg::MAP_W-1:0] reading_map;

  logic current_valid;
  sfhc_pkg::current_t current;
  logic [sfhc_pkg::SECONDS_W-1:0] current_seconds;
  logic [sfhc_pkg::MAP_W-1:0] current_map;

  logic [sfhc_pkg::SAMPLE_W-1:0] adc_sample;
  logic [sfhc_pkg::SECONDS_W-1:0] seconds;
  logic [sfhc_pkg::MAP_W-1:0] order_map;

  logic in_accept;
  logic last_sample;
  logic out_ready;
  logic cur_ready;
  logic rd_ready;
  logic [SUM_W-1:0] sum_next;
  logic [PROD_W-1:0] product;
  sfhc_pkg::current_t current_next;
  logic [sfhc_pkg::CURRENT_W-1:0] current_excess;
  logic [sfhc_pkg::MEAS_W-1:0] temp_measured;
  sfhc_pkg::temperature_t temperature;
  sfhc_pkg::stage_bits_t stage_flags_next;
  sfhc_pkg::stage_bits_t relay_outputs_next;
  logic relays_update;

  assign adc_sample = s_tdata[11:0];
  assign seconds    = s_tdata[17:12];
  assign order_map  = s_tdata[25:18];

  assign last_sample = (sample_count == LAST_COUNT);
  assign out_ready   = !m_tvalid || m_tready;
  assign cur_ready   = !current_valid || out_ready;
  assign rd_ready    = !reading_valid || cur_ready;
  assign s_tready    = rd_ready || !last_sample;
  assign in_accept   = s_tvalid && s_tready;

  assign sum_next = sample_sum + SUM_W'(adc_sample);

  assign product = PROD_W'(reading_sum) * PROD_W'(RECIP[RECIP_W-1:0]);
  assign current_next = sfhc_pkg::CURRENT_W'(product >> RECIP_SHIFT);

  always_comb begin
    if (current > sfhc_pkg::CURRENT_W'(sfhc_pkg::CURRENT_ZERO)) begin
      current_excess = current - sfhc_pkg::CURRENT_W'(sfhc_pkg::CURRENT_ZERO);
    end else begin
      current_excess = '0;
    end
    temp_measured = sfhc_pkg::MEAS_W'(current_excess) *
                    sfhc_pkg::MEAS_W'(sfhc_pkg::TEMP_SLOPE);
    if (test_mode) begin
      temperature = {test_temperature, 4'b0000};
    end else begin
      temperature = sfhc_pkg::TEMP_W'(temp_measured);
    end
  end

  always_comb begin
    logic [sfhc_pkg::LEVEL_W+3:0] on_level;
    logic [sfhc_pkg::LEVEL_W-1:0] off_base;
    logic [sfhc_pkg::LEVEL_W+3:0] off_level;
    logic off_reachable;
    logic [sfhc_pkg::RELAY_SEL_W-1:0] relay_sel;
    relay_sel = '0;
    stage_flags_next = stage_flags;
    for (int k = 0; k < sfhc_pkg::STAGE_W; k++) begin
      on_level      = {start_level[k], 4'b0000};
      off_base      = start_level[k] - hysteresis_width;
      off_level     = {off_base, 4'b0000};
      off_reachable = (start_level[k] >= hysteresis_width);
      if (k >= sfhc_pkg::STAGE_COUNT) begin
        stage_flags_next[k] = 1'b0;
      end else if (temperature > sfhc_pkg::TEMP_W'(on_level)) begin
        stage_flags_next[k] = 1'b1;
      end else if (off_reachable && (temperature < sfhc_pkg::TEMP_W'(off_level))) begin
        stage_flags_next[k] = 1'b0;
      end
    end

    relays_update = !(current_seconds inside {sfhc_pkg::HOLD_SEC_LATE,
                                              sfhc_pkg::HOLD_SEC_ZERO,
                                              sfhc_pkg::HOLD_SEC_EARLY});
    relay_outputs_next = relay_outputs;
    if (relays_update) begin
      for (int k = 0; k < sfhc_pkg::STAGE_W; k++) begin
        relay_sel = current_map[k*sfhc_pkg::RELAY_SEL_W +: sfhc_pkg::RELAY_SEL_W];
        if (k < sfhc_pkg::STAGE_COUNT) begin
          relay_outputs_next[relay_sel] = stage_flags_next[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_level[0]   <= sfhc_pkg::RESET_START_ONE;
      start_level[1]   <= sfhc_pkg::RESET_START_TWO;
      start_level[2]   <= sfhc_pkg::RESET_START_THREE;
      start_level[3]   <= sfhc_pkg::RESET_START_FOUR;
      hysteresis_width <= sfhc_pkg::RESET_HYSTERESIS;
      test_mode        <= 1'b0;
      test_temperature <= '0;
      sample_sum       <= '0;
      sample_count     <= '0;
      stage_flags      <= '0;
      relay_outputs    <= '0;
      reading_valid    <= 1'b0;
      current_valid    <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          sfhc_pkg::REG_START_ONE:        start_level[0]   <= cfg_data[7:0];
          sfhc_pkg::REG_START_TWO:        start_level[1]   <= cfg_data[7:0];
          sfhc_pkg::REG_START_THREE:      start_level[2]   <= cfg_data[7:0];
          sfhc_pkg::REG_START_FOUR:       start_level[3]   <= cfg_data[7:0];
          sfhc_pkg::REG_HYSTERESIS:       hysteresis_width <= cfg_data[7:0];
          sfhc_pkg::REG_TEST_MODE:        test_mode        <= cfg_data[0];
          sfhc_pkg::REG_TEST_TEMPERATURE: test_temperature <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        if (last_sample) begin
          sample_sum   <= '0;
          sample_count <= '0;
        end else begin
          sample_sum   <= sum_next;
          sample_count <= sample_count + CNT_W'(1);
        end
      end
      if (rd_ready) begin
        reading_valid <= in_accept && last_sample;
      end
      if (cur_ready) begin
        current_valid <= reading_valid;
      end
      if (out_ready) begin
        m_tvalid <= current_valid;
        if (current_valid) begin
          stage_flags   <= stage_flags_next;
          relay_outputs <= relay_outputs_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_ready && in_accept && last_sample) begin
      reading_sum     <= sum_next;
      reading_seconds <= seconds;
      reading_map     <= order_map;
    end
    if (cur_ready && reading_valid) begin
      current         <= current_next;
      current_seconds <= reading_seconds;
      current_map     <= reading_map;
    end
    if (out_ready && current_valid) begin
      m_tdata <= {3'b000, relay_outputs_next, stage_flags_next, temperature, current};
      m_tuser <= relays_update;
    end
  end

endmodule

/* design/sfhc_checker.sv */
// Port-level checker for the staged fan hysteresis controller, bound to the top.
// Depends on sfhc_pkg and staged_fan_hysteresis_control_defines.svh.
`include "staged_fan_hysteresis_control_defines.svh"

module sfhc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [sfhc_pkg::OUT_DATA_W-1:0]   m_tdata,
  input logic                              m_tuser
);

  sfhc_pkg::current_t out_current;
  sfhc_pkg::temperature_t out_temperature;
  sfhc_pkg::stage_bits_t out_stages;
  sfhc_pkg::temperature_t expected_measured;

  assign out_current     = m_tdata[8:0];
  assign out_temperature = m_tdata[28:9];
  assign out_stages      = m_tdata[32:29];

  always_comb begin
    if (out_current > sfhc_pkg::CURRENT_W'(sfhc_pkg::CURRENT_ZERO)) begin
      expected_measured = sfhc_pkg::TEMP_W'(out_current -
                                            sfhc_pkg::CURRENT_W'(sfhc_pkg::CURRENT_ZERO)) *
                          sfhc_pkg::TEMP_W'(sfhc_pkg::TEMP_SLOPE);
    end else begin
      expected_measured = '0;
    end
  end

  // A stalled result keeps its contents.
  `SFHC_ASSERT_NEXT(a_stall_holds, clk, rst, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // The averaged current never exceeds the full-scale converter value.
  `SFHC_ASSERT_SAME(a_current_range, clk, rst, m_tvalid,
                    out_current <= sfhc_pkg::CURRENT_W'(sfhc_pkg::CURRENT_MAX))

  // The temperature is either the one derived from this current or a whole degree.
  `SFHC_ASSERT_SAME(a_temperature_source, clk, rst, m_tvalid,
                    (out_temperature == expected_measured) || (out_temperature[3:0] == 4'd0))

  // Stages above the ones in use are never demanded.
  `SFHC_ASSERT_SAME(a_unused_stages, clk, rst, m_tvalid,
                    (out_stages >> sfhc_pkg::STAGE_COUNT) == '0)

  // No result is presented right after reset.
  `SFHC_ASSERT_SAME(a_reset_empty, clk, rst, $past(rst), !m_tvalid)

endmodule

bind staged_fan_hysteresis_control sfhc_checker u_sfhc_checker (.*);
